@@ hdl/wdnr_pkg.sv @@
// Shared types and constants for the wide-to-narrow decimal rescaler.
package wdnr_pkg;

    localparam int WIDE_BITS_DEF   = 256;
    localparam int NARROW_BITS_DEF = 96;

    localparam int LIMB_W      = 32;
    localparam int WORD_W      = 64;
    localparam int N_WORDS     = 4;
    localparam int IN_MANT_W   = N_WORDS * WORD_W;
    localparam int OUT_LOW_W   = 64;
    localparam int OUT_HIGH_W  = 32;
    localparam int OUT_MANT_W  = OUT_LOW_W + OUT_HIGH_W;
    localparam int IN_SCALE_W  = 7;
    localparam int OUT_SCALE_W = 5;
    localparam int MAX_SCALE   = 28;

    // divide-by-ten unit: remainder, running dividend, reciprocal
    localparam int RADIX       = 10;
    localparam int ROUND_MIN   = 5;
    localparam int REM_W       = 4;
    localparam int CUR_W       = REM_W + LIMB_W;
    localparam int RECIP_W     = 33;
    localparam int RECIP_SHIFT = 36;
    localparam int PROD_W      = CUR_W + RECIP_W;
    // floor(2**36 / 10)
    localparam logic [RECIP_W-1:0] DIV_RECIP = 33'h1_9999_9999;

    typedef struct packed {
        logic [WORD_W-1:0]     mant_w0;
        logic [WORD_W-1:0]     mant_w1;
        logic [WORD_W-1:0]     mant_w2;
        logic [WORD_W-1:0]     mant_w3;
        logic [IN_SCALE_W-1:0] in_scale;
        logic                  in_sign;
    } t_in_word;

    typedef struct packed {
        logic [OUT_LOW_W-1:0]   out_low;
        logic [OUT_HIGH_W-1:0]  out_high;
        logic [OUT_SCALE_W-1:0] out_scale;
        logic                   out_sign;
        logic                   overflow;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic start;
        logic div;
        logic round;
    } t_mant_ctrl;

    typedef struct packed {
        logic above;
        logic last;
        logic zero;
    } t_mant_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ROUND,
        S_DONE
    } t_state;

endpackage

@@ hdl/wdnr_div10.sv @@
// Divides one 32-bit limb plus carried-in remainder by ten.
module wdnr_div10 import wdnr_pkg::*; (
    input  logic [REM_W-1:0]  i_rem,
    input  logic [LIMB_W-1:0] i_limb,
    output logic [LIMB_W-1:0] o_quot,
    output logic [REM_W-1:0]  o_rem
);

    logic [CUR_W-1:0]   cur;
    logic [PROD_W-1:0]  prod;
    logic [RECIP_W-1:0] q_est;
    logic [CUR_W-1:0]   q_times;
    logic [CUR_W-1:0]   rem_est;
    logic               fix;

    always_comb begin
        cur     = {i_rem, i_limb};
        prod    = PROD_W'(cur) * PROD_W'(DIV_RECIP);
        // estimate is low by at most one
        q_est   = prod[RECIP_SHIFT +: RECIP_W];
        // times ten as eight plus two
        q_times = (CUR_W'(q_est) << 3) + (CUR_W'(q_est) << 1);
        rem_est = cur - q_times;
        fix     = rem_est >= CUR_W'(RADIX);
        if (fix) begin
            o_quot = LIMB_W'(q_est + RECIP_W'(1));
            o_rem  = REM_W'(rem_est - CUR_W'(RADIX));
        end else begin
            o_quot = LIMB_W'(q_est);
            o_rem  = REM_W'(rem_est);
        end
    end

endmodule

@@ hdl/wdnr_mant.sv @@
// Wide mantissa register, limb walk and round-up increment.
module wdnr_mant import wdnr_pkg::*; #(
    parameter int WIDE_BITS   = WIDE_BITS_DEF,
    parameter int NARROW_BITS = NARROW_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mant_ctrl            i_ctrl,
    input  logic [IN_MANT_W-1:0]  i_wide,
    output t_mant_stat            o_stat,
    output logic [OUT_MANT_W-1:0] o_narrow
);

    localparam int LIMBS  = (WIDE_BITS + LIMB_W - 1) / LIMB_W;
    localparam int MANT_W = LIMBS * LIMB_W;
    localparam int IDX_W  = $clog2(LIMBS);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(LIMBS - 1);

    logic [MANT_W-1:0]           r_mant, n_mant;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [IN_MANT_W+MANT_W-1:0] wide_ext;
    logic [MANT_W-1:0]           wide_mask;
    logic [MANT_W-1:0]           high_mask;
    logic [LIMB_W-1:0]           limb_in;
    logic [LIMB_W-1:0]           quot;
    logic [REM_W-1:0]            rem_out;

    assign wide_ext  = {{MANT_W{1'b0}}, i_wide};
    assign wide_mask = {MANT_W{1'b1}} >> (MANT_W - WIDE_BITS);
    assign high_mask = {MANT_W{1'b1}} << NARROW_BITS;
    assign limb_in   = r_mant[r_idx*LIMB_W +: LIMB_W];

    wdnr_div10 u_div10 (
        .i_rem  (r_rem),
        .i_limb (limb_in),
        .o_quot (quot),
        .o_rem  (rem_out)
    );

    always_comb begin
        n_mant = r_mant;
        n_idx  = r_idx;
        n_rem  = r_rem;
        priority if (i_ctrl.load) begin
            n_mant = wide_ext[MANT_W-1:0] & wide_mask;
        end else if (i_ctrl.start) begin
            n_idx = TOP_IDX;
            n_rem = '0;
        end else if (i_ctrl.div) begin
            n_mant[r_idx*LIMB_W +: LIMB_W] = quot;
            n_rem = rem_out;
            n_idx = r_idx - IDX_W'(1);
        end else if (i_ctrl.round) begin
            // half up: carry runs across the whole word
            if (r_rem >= REM_W'(ROUND_MIN)) begin
                n_mant = r_mant + MANT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mant <= n_mant;
        if (!i_rst_n) begin
            r_idx <= '0;
            r_rem <= '0;
        end else begin
            r_idx <= n_idx;
            r_rem <= n_rem;
        end
    end

    assign o_stat.above = |(r_mant & high_mask);
    assign o_stat.last  = (r_idx == '0);
    assign o_stat.zero  = (r_mant[OUT_MANT_W-1:0] == '0);
    assign o_narrow     = r_mant[OUT_MANT_W-1:0];

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < REM_W'(RADIX))
        else $error("remainder out of range");

    a_start_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start && !i_ctrl.load |=> r_idx == TOP_IDX && r_rem == '0)
        else $error("limb walk did not start at the top limb");

    a_walk_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div && !i_ctrl.load && !i_ctrl.start && r_idx != '0
        |=> r_idx == $past(r_idx) - IDX_W'(1))
        else $error("limb walk skipped a limb");

endmodule

@@ hdl/wide_decimal_narrow_round.sv @@
// Wide decimal mantissa narrowed to 96 bits with repeated divide-by-ten rounding.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a 256-bit unsigned
// mantissa in four 64-bit words, a 7-bit scale and a sign. A word is taken
// at a clock edge with valid high and stall low. Stall is high for the whole
// time one item is being worked on.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result word per
// input word: 96-bit mantissa, 5-bit scale, sign and overflow flag.
// Each narrowing step divides the mantissa by ten one 32-bit limb per cycle,
// top limb first, through a single reciprocal-multiply divider, then applies
// the half-up increment. The number of steps per item is the larger of the
// scale excess over 28 and the divisions by ten that bring the value under
// 2**96, where rounding up can cost one more. A new word is not taken until
// the previous result is loaded into the result register.
// The result register frees the input side: a new word is taken while the
// previous result still waits. A finished item holds until that register
// is empty or being read.
// Reset (synchronous, active low) returns to idle and drops any pending result.
module wide_decimal_narrow_round import wdnr_pkg::*; #(
    parameter int WIDE_BITS   = WIDE_BITS_DEF,
    parameter int NARROW_BITS = NARROW_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int SCALE_W = $clog2(WIDE_BITS) + 2;
    localparam logic signed [SCALE_W-1:0] MAX_SCALE_S = SCALE_W'(MAX_SCALE);

    t_state                    r_state, n_state;
    logic signed [SCALE_W-1:0] r_scale, n_scale;
    logic                      r_sign;
    logic                      r_out_valid;
    t_out_word                 r_out, n_out;
    t_mant_ctrl                ctrl;
    t_mant_stat                stat;
    logic [OUT_MANT_W-1:0]     narrow;
    logic                      in_accept;
    logic                      out_free;
    logic                      need_step;
    logic                      load_out;
    logic                      neg;

    wdnr_mant #(
        .WIDE_BITS   (WIDE_BITS),
        .NARROW_BITS (NARROW_BITS)
    ) u_mant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_wide   ({i_in_data.mant_w3, i_in_data.mant_w2,
                    i_in_data.mant_w1, i_in_data.mant_w0}),
        .o_stat   (stat),
        .o_narrow (narrow)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign need_step = stat.above || (r_scale > MAX_SCALE_S);
    assign neg       = r_scale[SCALE_W-1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = need_step ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (stat.last) n_state = S_ROUND;
            end
            S_ROUND: begin
                n_state = S_CHECK;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl     = '0;
        load_out = 1'b0;
        n_scale  = r_scale;
        unique case (r_state)
            S_IDLE: begin
                ctrl.load = i_in_valid;
                if (i_in_valid) n_scale = $signed(SCALE_W'(i_in_data.in_scale));
            end
            S_CHECK: begin
                ctrl.start = need_step;
            end
            S_DIV: begin
                ctrl.div = 1'b1;
            end
            S_ROUND: begin
                ctrl.round = 1'b1;
                n_scale    = r_scale - SCALE_W'(1);
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: ctrl = '0;
        endcase
    end

    always_comb begin
        n_out.out_low   = narrow[OUT_LOW_W-1:0];
        n_out.out_high  = narrow[OUT_MANT_W-1:OUT_LOW_W];
        n_out.out_sign  = r_sign;
        n_out.overflow  = neg;
        // zero mantissa or overflow reports scale zero
        n_out.out_scale = (neg || stat.zero) ? '0 : OUT_SCALE_W'(r_scale);
    end

    always_ff @(posedge i_clk) begin
        r_scale <= n_scale;
        if (in_accept) r_sign <= i_in_data.in_sign;
        if (load_out) r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_CHECK)
        else $error("accepted word did not enter the check state");

    a_done_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> !stat.above && r_scale <= MAX_SCALE_S)
        else $error("result still out of range");

    a_round_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |=> r_scale == $past(r_scale) - SCALE_W'(1)
            && r_state == S_CHECK)
        else $error("scale not lowered after a step");

    a_ovf_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid && (!r_out.overflow || r_out.out_scale == '0))
        else $error("overflow result carries a scale");

endmodule

@@ tb/sv/wide_decimal_narrow_round_tb.sv @@
// Self-checking bench for the wide-to-narrow decimal rescaler: directed table, then random words.
module wide_decimal_narrow_round_tb;
    import wdnr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1550;
    localparam int CALM_TAIL = 150;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_data;

    t_out_word pending_narrow[$];
    int        mismatches = 0;
    int        quiet = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;

    wide_decimal_narrow_round dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #6 clk = ~clk;

    // Divide by ten with half-up rounding until the value fits 96 bits and the scale 28.
    function automatic t_out_word narrow_round(input t_in_word w);
        logic [IN_MANT_W-1:0] m;
        logic [IN_MANT_W-1:0] q;
        int                   sc;
        t_out_word            r;
        m  = {w.mant_w3, w.mant_w2, w.mant_w1, w.mant_w0};
        sc = int'(w.in_scale);
        while (m[IN_MANT_W-1:OUT_MANT_W] != '0 || sc > MAX_SCALE) begin
            q = m / RADIX;
            if (m % RADIX >= ROUND_MIN) begin
                q = q + 1'b1;
            end
            m  = q;
            sc = sc - 1;
        end
        r.out_low  = m[OUT_LOW_W-1:0];
        r.out_high = m[OUT_MANT_W-1:OUT_LOW_W];
        r.overflow = (sc < 0);
        r.out_sign = w.in_sign;
        if (sc < 0 || m == '0) begin
            sc = 0;
        end
        r.out_scale = sc[OUT_SCALE_W-1:0];
        return r;
    endfunction

    function automatic t_in_word mk_in(input logic [IN_MANT_W-1:0] m, input int sc, input bit sg);
        t_in_word w;
        {w.mant_w3, w.mant_w2, w.mant_w1, w.mant_w0} = m;
        w.in_scale = sc[IN_SCALE_W-1:0];
        w.in_sign  = sg;
        return w;
    endfunction

    function automatic t_out_word mk_out(input logic [OUT_LOW_W-1:0] lo,
                                         input logic [OUT_HIGH_W-1:0] hi,
                                         input int sc, input bit sg, input bit ovf);
        t_out_word r;
        r.out_low   = lo;
        r.out_high  = hi;
        r.out_scale = sc[OUT_SCALE_W-1:0];
        r.out_sign  = sg;
        r.overflow  = ovf;
        return r;
    endfunction

    function automatic logic [IN_MANT_W-1:0] rand_bits();
        logic [IN_MANT_W-1:0] v;
        for (int i = 0; i < IN_MANT_W / 32; i++) begin
            v[i*32 +: 32] = $urandom;
        end
        return v;
    endfunction

    // Mostly values with a random top bit and modest scale; some full-width, boundary,
    // rounding-edge and tiny values.
    function automatic t_in_word rand_word();
        logic [IN_MANT_W-1:0] m;
        int                   sc;
        int                   top;
        int                   kind;
        kind = $urandom_range(0, 9);
        sc   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 34);
        case (kind)
            0: begin
                m  = rand_bits();
                sc = $urandom_range(0, 127);
            end
            1: m = (256'd1 << OUT_MANT_W) + $urandom_range(0, 20) - 10;
            2: begin
                m  = (rand_bits() >> 164) * RADIX + ($urandom_range(0, 1) ? 5 : 4)
                     + ($urandom_range(0, 1) ? 4 : 0);
                sc = $urandom_range(29, 31);
            end
            3: m = $urandom_range(0, 99);
            default: begin
                top    = $urandom_range(0, IN_MANT_W - 1);
                m      = rand_bits() & ((256'd1 << (top + 1)) - 1'b1);
                m[top] = 1'b1;
            end
        endcase
        return mk_in(m, sc, $urandom_range(0, 1));
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // Present one word, hold it until taken, then log what it should produce.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        pending_narrow.push_back(typed ? want : narrow_round(w));
    endtask

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_narrow.size() == 0) begin
                flag_mismatch("result word with none pending", out_data.out_low, '0);
            end else begin
                want = pending_narrow.pop_front();
                if (out_data.out_low !== want.out_low)
                    flag_mismatch("out_low", out_data.out_low, want.out_low);
                if (out_data.out_high !== want.out_high)
                    flag_mismatch("out_high", out_data.out_high, want.out_high);
                if (out_data.out_scale !== want.out_scale)
                    flag_mismatch("out_scale", out_data.out_scale, want.out_scale);
                if (out_data.out_sign !== want.out_sign)
                    flag_mismatch("out_sign", out_data.out_sign, want.out_sign);
                if (out_data.overflow !== want.overflow)
                    flag_mismatch("overflow", out_data.overflow, want.overflow);
            end
        end
        // stall the result side in short bursts
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_row rows[$];
        rows.push_back('{mk_in('0, 0, 0), 1'b1, mk_out('0, '0, 0, 0, 0)});
        rows.push_back('{mk_in('0, 127, 1), 1'b1, mk_out('0, '0, 0, 1, 0)});
        rows.push_back('{mk_in((256'd1 << 96) - 1'b1, 28, 0), 1'b1,
                         mk_out('1, '1, 28, 0, 0)});
        rows.push_back('{mk_in(256'd1 << 95, 28, 1), 1'b1,
                         mk_out('0, 32'h8000_0000, 28, 1, 0)});
        // half rounds up, just under half rounds down to zero
        rows.push_back('{mk_in(256'd5, 29, 0), 1'b1, mk_out(64'd1, '0, 28, 0, 0)});
        rows.push_back('{mk_in(256'd4, 29, 0), 1'b1, mk_out('0, '0, 0, 0, 0)});
        rows.push_back('{mk_in(256'd9, 29, 1), 1'b1, mk_out(64'd1, '0, 28, 1, 0)});
        // double rounding: 149 -> 15 -> 2
        rows.push_back('{mk_in(256'd149, 30, 0), 1'b1, mk_out(64'd2, '0, 28, 0, 0)});
        // increment carries out of the low 64 bits
        rows.push_back('{mk_in((256'd10 << 64) - 256'd5, 29, 0), 1'b1,
                         mk_out('0, 32'd1, 28, 0, 0)});
        rows.push_back('{mk_in('1, 0, 0), 1'b0, '0});
        rows.push_back('{mk_in('1, 127, 1), 1'b0, '0});
        rows.push_back('{mk_in('1, 40, 0), 1'b0, '0});
        rows.push_back('{mk_in(256'd1 << 96, 0, 1), 1'b0, '0});
        rows.push_back('{mk_in(256'd1 << 96, 1, 0), 1'b0, '0});
        rows.push_back('{mk_in({64'hFFFF_FFFF_FFFF_FFFF, 192'd0}, 50, 0), 1'b0, '0});
        rows.push_back('{mk_in({64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 128'd0}, 28, 1), 1'b0, '0});
        rows.push_back('{mk_in({128'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 5, 0), 1'b0, '0});
        rows.push_back('{mk_in({192'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 127, 0), 1'b0, '0});
        rows.push_back('{mk_in(256'h5555_5555_5555_5555_5555_5555_5555_5555_5555_5555_5555_5555,
                               85, 1), 1'b0, '0});
        rows.push_back('{mk_in(256'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA,
                               42, 0), 1'b0, '0});

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            send_word(rows[i].word, rows[i].typed, rows[i].result);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // no idling on either side for the tail
            if (n == RANDOM_WORDS - CALM_TAIL) begin
                idle_on = 1'b0;
            end
            send_word(rand_word(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_narrow.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
